@@ rtl/assert_macros.svh @@
// Assertion macros for the HTTP response deframer RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

@@ rtl/hrd_pkg.sv @@
// Shared types and constants for the HTTP response deframer.
// No dependencies.
package hrd_pkg;
    localparam int COUNT_BITS = 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [16:0] STATUS_LIMIT = 17'd99999;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    // queue entry between front and back
    typedef struct packed {
        logic [7:0]  body_byte;
        logic        is_final;
        logic [1:0]  result_code;
        logic [17:0] http_status;
        logic [31:0] discard_tail;
    } hrd_res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction
    function automatic logic [7:0] to_low(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction
    // hex digit: {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] l;
        l = to_low(c);
        if (is_dig(c)) return {1'b1, c[3:0]};
        if (l >= 8'd97 && l <= 8'd102) return {1'b1, 4'(l - 8'd87)};
        return 5'd0;
    endfunction
    function automatic logic [7:0] te_char(input logic [4:0] i);
        case (i)
            5'd0: return "t";  5'd1: return "r";  5'd2: return "a";  5'd3: return "n";
            5'd4: return "s";  5'd5: return "f";  5'd6: return "e";  5'd7: return "r";
            5'd8: return "-";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "c";
            5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
            5'd16: return "g";
            default: return 8'd0;
        endcase
    endfunction
    function automatic logic [7:0] cl_char(input logic [4:0] i);
        case (i)
            5'd0: return "c";  5'd1: return "o";  5'd2: return "n";  5'd3: return "t";
            5'd4: return "e";  5'd5: return "n";  5'd6: return "t";  5'd7: return "-";
            5'd8: return "l";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "g";
            5'd12: return "t"; 5'd13: return "h";
            default: return 8'd0;
        endcase
    endfunction
    function automatic logic [7:0] ch_char(input logic [2:0] i);
        case (i)
            3'd0: return "c"; 3'd1: return "h"; 3'd2: return "u"; 3'd3: return "n";
            3'd4: return "k"; 3'd5: return "e"; 3'd6: return "d";
            default: return 8'd0;
        endcase
    endfunction
endpackage

@@ rtl/hrd_front.sv @@
// Front end: parses status, headers and chunk framing, one beat per cycle.
// Depends on hrd_pkg.
module hrd_front import hrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    output logic        res_valid,
    output hrd_res_t    res
);
    localparam logic [2:0] PH_STATUS = 3'd0, PH_HEADER = 3'd1, PH_BODY = 3'd2,
                           PH_CHUNK = 3'd3, PH_IGNORE = 3'd4;
    localparam logic [1:0] LM_NAME = 2'd0, LM_CL = 2'd1, LM_TE = 2'd2, LM_OTHER = 2'd3;
    localparam logic [3:0] CS_WS = 4'd0, CS_SIGN = 4'd1, CS_DIG = 4'd2, CS_ZERO = 4'd4,
                           CS_PREFIX = 4'd5, CS_REST = 4'd6, CS_DATA = 4'd7,
                           CS_SKIP = 4'd8, CS_STOP = 4'd9;

    logic [2:0]  phase_reg, phase_next;
    logic [23:0] recent_reg, recent_next;
    logic [16:0] st_acc_reg, st_acc_next;
    logic [1:0]  st_spaces_reg, st_spaces_next, st_sub_reg, st_sub_next;
    logic [1:0]  st_result_reg, st_result_next;
    logic        st_neg_reg, st_neg_next, st_digit_reg, st_digit_next;
    logic [4:0]  nm_pos_reg, nm_pos_next;
    logic [1:0]  nm_flags_reg, nm_flags_next, line_mode_reg, line_mode_next;
    logic [2:0]  ch_pos_reg, ch_pos_next;
    logic        chunked_reg, chunked_next;
    logic [COUNT_BITS-1:0] val_acc_reg, val_acc_next;
    logic [1:0]  val_sub_reg, val_sub_next;
    logic        val_neg_reg, val_neg_next, val_digit_reg, val_digit_next;
    logic [COUNT_BITS-1:0] len_reg, len_next;
    logic        len_valid_reg, len_valid_next;
    logic [3:0]  cs_reg, cs_next;
    logic        skip_reg, skip_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next, body_reg, body_next;
    logic        res_valid_next;
    hrd_res_t    res_next;

    logic [7:0]  c, lc, prev;
    logic [4:0]  hx;
    logic        emit;
    logic [COUNT_BITS+3:0] dec_mul;
    logic [COUNT_BITS+4:0] dec_sum;
    logic [20:0] st_mul;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_STATUS; recent_reg <= '0; st_acc_reg <= '0;
            st_spaces_reg <= '0; st_sub_reg <= '0; st_result_reg <= '0;
            st_neg_reg <= 1'b0; st_digit_reg <= 1'b0;
            nm_pos_reg <= '0; nm_flags_reg <= 2'b11; line_mode_reg <= LM_NAME;
            ch_pos_reg <= '0; chunked_reg <= 1'b0;
            val_acc_reg <= '0; val_sub_reg <= '0; val_neg_reg <= 1'b0;
            val_digit_reg <= 1'b0; len_reg <= '0; len_valid_reg <= 1'b0;
            cs_reg <= CS_WS; skip_reg <= 1'b0; rem_reg <= '0; body_reg <= '0;
            res_valid <= 1'b0;
        end else begin
            phase_reg <= phase_next; recent_reg <= recent_next; st_acc_reg <= st_acc_next;
            st_spaces_reg <= st_spaces_next; st_sub_reg <= st_sub_next;
            st_result_reg <= st_result_next; st_neg_reg <= st_neg_next;
            st_digit_reg <= st_digit_next; nm_pos_reg <= nm_pos_next;
            nm_flags_reg <= nm_flags_next; line_mode_reg <= line_mode_next;
            ch_pos_reg <= ch_pos_next; chunked_reg <= chunked_next;
            val_acc_reg <= val_acc_next; val_sub_reg <= val_sub_next;
            val_neg_reg <= val_neg_next; val_digit_reg <= val_digit_next;
            len_reg <= len_next; len_valid_reg <= len_valid_next;
            cs_reg <= cs_next; skip_reg <= skip_next; rem_reg <= rem_next;
            body_reg <= body_next; res_valid <= res_valid_next;
        end
    end
    always_ff @(posedge aclk) res <= res_next;

    // per-beat parse step
    always_comb begin
        phase_next = phase_reg; recent_next = recent_reg; st_acc_next = st_acc_reg;
        st_spaces_next = st_spaces_reg; st_sub_next = st_sub_reg;
        st_result_next = st_result_reg; st_neg_next = st_neg_reg;
        st_digit_next = st_digit_reg; nm_pos_next = nm_pos_reg;
        nm_flags_next = nm_flags_reg; line_mode_next = line_mode_reg;
        ch_pos_next = ch_pos_reg; chunked_next = chunked_reg;
        val_acc_next = val_acc_reg; val_sub_next = val_sub_reg;
        val_neg_next = val_neg_reg; val_digit_next = val_digit_reg;
        len_next = len_reg; len_valid_next = len_valid_reg; cs_next = cs_reg;
        skip_next = skip_reg; rem_next = rem_reg; body_next = body_reg;
        res_valid_next = 1'b0; res_next = '0; emit = 1'b0;
        c = in_byte; lc = to_low(in_byte); prev = recent_reg[7:0]; hx = hex_val(in_byte);
        dec_mul = {4'd0, val_acc_reg} * (COUNT_BITS+4)'(10);
        dec_sum = {1'b0, dec_mul} + (COUNT_BITS+5)'(c - 8'd48);
        st_mul = {4'd0, st_acc_reg} * 21'd10 + 21'(c - 8'd48);
        if (in_valid && in_end) begin
            // closing summary, then back to reset state
            res_valid_next = 1'b1;
            res_next.is_final = 1'b1;
            res_next.result_code = (phase_reg == PH_STATUS || phase_reg == PH_HEADER)
                                   ? 2'd1 : st_result_reg;
            if (res_next.result_code == 2'd0)
                res_next.http_status = st_neg_reg ? 18'(-{1'b0, st_acc_reg})
                                                  : {1'b0, st_acc_reg};
            if (phase_reg == PH_CHUNK && cs_reg == CS_DATA) res_next.discard_tail = body_reg;
            phase_next = PH_STATUS; recent_next = '0; st_acc_next = '0;
            st_spaces_next = '0; st_sub_next = '0; st_result_next = '0;
            st_neg_next = 1'b0; st_digit_next = 1'b0; nm_pos_next = '0;
            nm_flags_next = 2'b11; line_mode_next = LM_NAME; ch_pos_next = '0;
            chunked_next = 1'b0; val_acc_next = '0; val_sub_next = '0;
            val_neg_next = 1'b0; val_digit_next = 1'b0; len_next = '0;
            len_valid_next = 1'b0; cs_next = CS_WS; skip_next = 1'b0;
            rem_next = '0; body_next = '0;
        end else if (in_valid) begin
            recent_next = {recent_reg[15:0], c};
            case (phase_reg)
                PH_STATUS: begin
                    if (c == 8'd10 && prev == 8'd13) begin
                        if (st_spaces_reg < 2'd2) st_result_next = 2'd2;
                        else if (!st_digit_reg) st_result_next = 2'd3;
                        else st_result_next = 2'd0;
                        phase_next = PH_HEADER;
                        nm_pos_next = '0; nm_flags_next = 2'b11; line_mode_next = LM_NAME;
                        val_acc_next = '0; val_sub_next = '0;
                        val_neg_next = 1'b0; val_digit_next = 1'b0;
                    end else if (st_spaces_reg == 2'd0) begin
                        if (c == 8'd32) st_spaces_next = 2'd1;
                    end else if (st_spaces_reg == 2'd1) begin
                        if (c == 8'd32) st_spaces_next = 2'd2;
                        else if (st_sub_reg == 2'd0 && is_ws(c)) begin
                        end else if (st_sub_reg == 2'd0 && (c == "+" || c == "-")) begin
                            st_neg_next = (c == "-"); st_sub_next = 2'd1;
                        end else if (st_sub_reg <= 2'd2 && is_dig(c)) begin
                            st_acc_next = (st_mul > 21'(STATUS_LIMIT)) ? STATUS_LIMIT
                                                                      : st_mul[16:0];
                            st_digit_next = 1'b1; st_sub_next = 2'd2;
                        end else st_sub_next = 2'd3;
                    end
                end
                PH_HEADER: begin
                    if (c == 8'd10) begin
                        // CR LF CR before this LF closes the header section
                        if (recent_reg == 24'h0D0A0D) begin
                            recent_next = '0; body_next = '0;
                            if (st_result_reg != 2'd0) phase_next = PH_IGNORE;
                            else if (chunked_reg) begin
                                phase_next = PH_CHUNK; cs_next = CS_WS; rem_next = '0;
                            end else phase_next = PH_BODY;
                        end else begin
                            if (line_mode_reg == LM_CL && val_digit_reg) begin
                                if (val_neg_reg && val_acc_reg != '0) len_valid_next = 1'b0;
                                else begin
                                    len_next = val_acc_reg; len_valid_next = 1'b1;
                                end
                            end
                            nm_pos_next = '0; nm_flags_next = 2'b11; line_mode_next = LM_NAME;
                            val_acc_next = '0; val_sub_next = '0;
                            val_neg_next = 1'b0; val_digit_next = 1'b0;
                        end
                    end else begin
                        case (line_mode_reg)
                            LM_NAME: begin
                                if (c == ":") begin
                                    if (nm_pos_reg == 5'd17 && nm_flags_reg[0]) begin
                                        line_mode_next = LM_TE; chunked_next = 1'b0;
                                        ch_pos_next = '0;
                                    end else if (nm_pos_reg == 5'd14 && nm_flags_reg[1])
                                        line_mode_next = LM_CL;
                                    else line_mode_next = LM_OTHER;
                                end else begin
                                    if (!(nm_pos_reg < 5'd17 && te_char(nm_pos_reg) == lc))
                                        nm_flags_next[0] = 1'b0;
                                    if (!(nm_pos_reg < 5'd14 && cl_char(nm_pos_reg) == lc))
                                        nm_flags_next[1] = 1'b0;
                                    if (nm_pos_reg < 5'd31) nm_pos_next = nm_pos_reg + 5'd1;
                                end
                            end
                            LM_CL: begin
                                if (val_sub_reg == 2'd0 && is_ws(c)) begin
                                end else if (val_sub_reg == 2'd0 && (c == "+" || c == "-")) begin
                                    val_neg_next = (c == "-"); val_sub_next = 2'd1;
                                end else if (val_sub_reg <= 2'd2 && is_dig(c)) begin
                                    val_acc_next = (dec_sum[COUNT_BITS+4:COUNT_BITS] != '0)
                                                   ? COUNT_MAX : dec_sum[COUNT_BITS-1:0];
                                    val_digit_next = 1'b1; val_sub_next = 2'd2;
                                end else val_sub_next = 2'd3;
                            end
                            LM_TE: begin
                                if (!chunked_reg) begin
                                    if (ch_char(ch_pos_reg) == lc) ch_pos_next = ch_pos_reg + 3'd1;
                                    else ch_pos_next = (lc == "c") ? 3'd1 : 3'd0;
                                    if (ch_pos_next >= 3'd7) begin
                                        chunked_next = 1'b1; ch_pos_next = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                PH_BODY: begin
                    if (!len_valid_reg || body_reg < len_reg) begin
                        emit = 1'b1;
                        if (body_reg != COUNT_MAX) body_next = body_reg + COUNT_BITS'(1);
                    end
                end
                PH_CHUNK: begin
                    if (cs_reg <= CS_REST && c == 8'd10 && prev == 8'd13) begin
                        if (cs_reg == CS_REST) begin
                            cs_next = CS_DATA; body_next = '0;
                        end else cs_next = CS_STOP;
                    end else begin
                        case (cs_reg)
                            CS_WS, CS_SIGN, CS_ZERO, CS_PREFIX, CS_DIG: begin
                                if (cs_reg == CS_WS && is_ws(c)) begin
                                end else if (cs_reg == CS_WS && c == "+") cs_next = CS_SIGN;
                                else if ((cs_reg == CS_WS || cs_reg == CS_SIGN) && c == "0")
                                    cs_next = CS_ZERO;
                                else if (cs_reg == CS_ZERO && (c == "x" || c == "X"))
                                    cs_next = CS_PREFIX;
                                else if (hx[4]) begin
                                    if (cs_reg == CS_DIG &&
                                        rem_reg[COUNT_BITS-1:COUNT_BITS-4] != 4'd0)
                                        cs_next = CS_STOP;
                                    else begin
                                        rem_next = (cs_reg == CS_DIG)
                                            ? {rem_reg[COUNT_BITS-5:0], hx[3:0]}
                                            : COUNT_BITS'(hx[3:0]);
                                        cs_next = CS_DIG;
                                    end
                                end else if (cs_reg == CS_DIG)
                                    cs_next = (rem_reg == '0) ? CS_STOP : CS_REST;
                                else cs_next = CS_STOP;
                            end
                            CS_DATA: begin
                                emit = 1'b1;
                                rem_next = rem_reg - COUNT_BITS'(1);
                                if (body_reg != COUNT_MAX) body_next = body_reg + COUNT_BITS'(1);
                                if (rem_reg == COUNT_BITS'(1)) begin
                                    cs_next = CS_SKIP; skip_next = 1'b1;
                                end
                            end
                            CS_SKIP: begin
                                skip_next = 1'b0;
                                if (!skip_reg) begin
                                    cs_next = CS_WS; rem_next = '0; recent_next = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            if (emit) begin
                res_valid_next = 1'b1; res_next.body_byte = c;
            end
        end
    end
endmodule

@@ rtl/hrd_queue.sv @@
// Small result FIFO between front and back; registered output beat.
// Depends on hrd_pkg.
module hrd_queue import hrd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_en,
    input  hrd_res_t wr_data,
    output logic     full,
    output logic     m_valid,
    input  logic     m_ready,
    output hrd_res_t m_data
);
    hrd_res_t mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           rd;

    assign m_valid = (cnt_reg != '0);
    assign rd      = m_valid && m_ready;
    assign m_data  = mem[rp_reg];
    assign full    = (cnt_reg >= (QAW+1)'(QDEPTH-2));
    assign cnt_next = cnt_reg + (QAW+1)'(wr_en) - (QAW+1)'(rd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end
endmodule

@@ rtl/http_response_deframer_unit.sv @@
// HTTP/1.1 response deframer top level: parser front, result queue back.
// Depends on hrd_pkg, hrd_front, hrd_queue and assert_macros.svh.
//
// Usage: raw response bytes enter on s_data_byte, one beat each, with
// s_end_of_response marking the close of a response (no byte carried).
// Body bytes leave on m_body_byte with m_is_final low; the end beat yields
// one summary beat with m_is_final high carrying result code, status and
// the count of trailing bytes from a cut-off chunk.
// Throughput: one input beat per cycle while the queue has room.
// Path: a result reaches m_* from its input beat through one front register
// stage and then one queue write; a low m_ready can hold it in the queue.
// Reset: all parse state returns to the status line phase; queue empty.
// Stall: when m_ready is low the four-entry queue fills; s_ready drops once
// two entries are held, leaving room for the beat in the front register.
`include "assert_macros.svh"
module http_response_deframer_unit import hrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_response,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_body_byte,
    output logic        m_is_final,
    output logic [1:0]  m_result_code,
    output logic signed [17:0] m_http_status,
    output logic [31:0] m_discard_tail
);
    logic     full, res_valid;
    hrd_res_t res, q_out;

    assign s_ready = !full;

    hrd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid && s_ready),
        .in_byte(s_data_byte), .in_end(s_end_of_response),
        .res_valid(res_valid), .res(res)
    );

    hrd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(res_valid), .wr_data(res),
        .full(full), .m_valid(m_valid), .m_ready(m_ready), .m_data(q_out)
    );

    assign m_body_byte    = q_out.body_byte;
    assign m_is_final     = q_out.is_final;
    assign m_result_code  = q_out.result_code;
    assign m_http_status  = q_out.http_status;
    assign m_discard_tail = q_out.discard_tail;

    // assertions
    `ASSERT_NEXT(a_end_gives_final, aclk, aresetn, s_valid && s_ready && s_end_of_response, res_valid && res.is_final)
    `ASSERT_IMPLY(a_byte_beat_clean, aclk, aresetn, m_valid && !m_is_final, m_result_code == 2'd0 && m_discard_tail == 32'd0)
    `ASSERT_IMPLY(a_no_overflow, aclk, aresetn, res_valid, u_queue.cnt_reg < 3'd4 || m_ready)
endmodule

@@ verif/tb_http_response_deframer_unit.sv @@
// Testbench for http_response_deframer_unit: random and directed HTTP responses,
// checked beat by beat against an in-bench deframer predictor.
// Depends on hrd_pkg and the RTL of http_response_deframer_unit.
`timescale 1ns / 100ps

module tb_http_response_deframer_unit;
    import hrd_pkg::*;

    // predictor phase and sub-state codes
    localparam int PH_STATUS = 0, PH_HEADER = 1, PH_BODY = 2, PH_CHUNK = 3, PH_IGNORE = 4;
    localparam int LN_NAME = 0, LN_CLEN = 1, LN_TENC = 2, LN_OTHER = 3;
    localparam int SZ_WS = 0, SZ_SIGN = 1, SZ_DIG = 2, SZ_ZERO = 4, SZ_PREFIX = 5,
                   SZ_REST = 6, SZ_DATA = 7, SZ_SKIP = 8, SZ_STOP = 9;
    localparam int RC_OK = 0, RC_NO_SEP = 1, RC_BAD_LINE = 2, RC_BAD_CODE = 3;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [7:0] data;
        logic       eor;
        logic       drain;
    } beat_t;

    typedef struct {
        logic [7:0]         body_byte;
        logic               is_final;
        logic [1:0]         result_code;
        logic signed [17:0] http_status;
        logic [31:0]        discard_tail;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic s_end_of_response = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_body_byte;
    logic m_is_final;
    logic [1:0] m_result_code;
    logic signed [17:0] m_http_status;
    logic [31:0] m_discard_tail;

    http_response_deframer_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_end_of_response(s_end_of_response),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_body_byte(m_body_byte), .m_is_final(m_is_final),
        .m_result_code(m_result_code), .m_http_status(m_http_status),
        .m_discard_tail(m_discard_tail)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    beat_t   pending_beats[$];
    result_t body_expect[$];
    int      err_cnt = 0;
    int      idle_cycles = 0;

    // ---------------- deframer predictor state ----------------
    int          ph;
    logic [23:0] last3;
    logic [16:0] st_acc;
    int          st_spaces, st_sub, st_code;
    bit          st_neg, st_digit;
    int          nm_pos, ln_mode;
    logic [1:0]  nm_flags;
    int          ck_pos;
    bit          ck_mode;
    logic [31:0] v_acc;
    int          v_sub;
    bit          v_neg, v_digit;
    logic [31:0] len_lim;
    bit          len_ok;
    int          sz_sub, skip_cnt;
    logic [31:0] chunk_left;
    logic [31:0] emitted;
    string       te_word = "transfer-encoding";
    string       cl_word = "content-length";
    string       ck_word = "chunked";

    function automatic bit blank(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit decimal(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction
    // -1 when not a hex digit
    function automatic int nibble(logic [7:0] c);
        logic [7:0] l;
        l = lower(c);
        if (decimal(c)) return int'(c) - 48;
        if (l >= "a" && l <= "f") return int'(l) - 87;
        return -1;
    endfunction

    task automatic new_line();
        nm_pos = 0; nm_flags = 2'b11; ln_mode = LN_NAME;
        v_acc = 0; v_sub = 0; v_neg = 0; v_digit = 0;
    endtask

    task automatic clear_parser();
        ph = PH_STATUS; last3 = 0;
        st_acc = 0; st_spaces = 0; st_sub = 0; st_code = RC_OK; st_neg = 0; st_digit = 0;
        new_line();
        ck_pos = 0; ck_mode = 0; len_lim = 0; len_ok = 0;
        sz_sub = SZ_WS; skip_cnt = 0; chunk_left = 0; emitted = 0;
    endtask

    task automatic status_char(logic [7:0] c);
        if (st_sub == 0 && blank(c)) return;
        if (st_sub == 0 && (c == "+" || c == "-")) begin
            st_neg = (c == "-"); st_sub = 1; return;
        end
        if (st_sub <= 2 && decimal(c)) begin
            st_acc = (st_acc * 10 + (c - 48) > STATUS_LIMIT) ? STATUS_LIMIT
                                                             : st_acc * 10 + (c - 48);
            st_digit = 1; st_sub = 2; return;
        end
        st_sub = 3;
    endtask

    task automatic clen_char(logic [7:0] c);
        logic [31:0] d;
        d = c - 8'd48;
        if (v_sub == 0 && blank(c)) return;
        if (v_sub == 0 && (c == "+" || c == "-")) begin
            v_neg = (c == "-"); v_sub = 1; return;
        end
        if (v_sub <= 2 && decimal(c)) begin
            if (v_acc > (CNT_MAX - d) / 10) v_acc = CNT_MAX;
            else v_acc = v_acc * 10 + d;
            v_digit = 1; v_sub = 2; return;
        end
        v_sub = 3;
    endtask

    task automatic field_char(logic [7:0] c);
        logic [7:0] lc;
        lc = lower(c);
        if (ln_mode == LN_NAME) begin
            if (c == ":") begin
                if (nm_pos == 17 && nm_flags[0]) begin
                    ln_mode = LN_TENC; ck_mode = 0; ck_pos = 0;
                end else if (nm_pos == 14 && nm_flags[1]) ln_mode = LN_CLEN;
                else ln_mode = LN_OTHER;
                return;
            end
            if (!(nm_pos < 17 && te_word[nm_pos] == lc)) nm_flags[0] = 1'b0;
            if (!(nm_pos < 14 && cl_word[nm_pos] == lc)) nm_flags[1] = 1'b0;
            if (nm_pos < 31) nm_pos++;
        end else if (ln_mode == LN_CLEN) begin
            clen_char(c);
        end else if (ln_mode == LN_TENC && !ck_mode) begin
            if (ck_word[ck_pos] == lc) ck_pos++;
            else ck_pos = (lc == "c") ? 1 : 0;
            if (ck_pos >= 7) begin
                ck_mode = 1; ck_pos = 0;
            end
        end
    endtask

    function automatic void size_nibble(int d);
        if (chunk_left > (CNT_MAX >> 4)) begin
            sz_sub = SZ_STOP; return;
        end
        chunk_left = (chunk_left << 4) | d;
        sz_sub = SZ_DIG;
    endfunction

    // returns 1 when the byte is body data
    function automatic bit chunk_byte(logic [7:0] c, logic [7:0] prev);
        int d;
        d = nibble(c);
        if (sz_sub <= SZ_REST && c == 8'd10 && prev == 8'd13) begin
            if (sz_sub == SZ_REST) begin
                sz_sub = SZ_DATA; emitted = 0;
            end else sz_sub = SZ_STOP;
            return 0;
        end
        case (sz_sub)
            SZ_WS, SZ_SIGN: begin
                if (sz_sub == SZ_WS && blank(c)) return 0;
                if (sz_sub == SZ_WS && c == "+") begin
                    sz_sub = SZ_SIGN; return 0;
                end
                if (c == "0") sz_sub = SZ_ZERO;
                else if (d >= 0) begin
                    chunk_left = 0; size_nibble(d);
                end else sz_sub = SZ_STOP;
            end
            SZ_ZERO: begin
                if (c == "x" || c == "X") sz_sub = SZ_PREFIX;
                else if (d >= 0) begin
                    chunk_left = 0; size_nibble(d);
                end else sz_sub = SZ_STOP;
            end
            SZ_PREFIX: begin
                if (d >= 0) begin
                    chunk_left = 0; size_nibble(d);
                end else sz_sub = SZ_STOP;
            end
            SZ_DIG: begin
                if (d >= 0) size_nibble(d);
                else sz_sub = (chunk_left == 0) ? SZ_STOP : SZ_REST;
            end
            SZ_DATA: begin
                chunk_left--;
                if (emitted != CNT_MAX) emitted++;
                if (chunk_left == 0) begin
                    sz_sub = SZ_SKIP; skip_cnt = 2;
                end
                return 1;
            end
            SZ_SKIP: begin
                skip_cnt--;
                if (skip_cnt == 0) begin
                    sz_sub = SZ_WS; chunk_left = 0; last3 = 0;
                end
            end
            default: ;
        endcase
        return 0;
    endfunction

    // advance the predictor by one accepted beat, queue any result it yields
    task automatic deframe_beat(logic [7:0] c, logic eor);
        logic [7:0]  prev;
        logic [23:0] tail;
        bit          out_byte;
        result_t     r;
        prev = last3[7:0];
        tail = last3;
        out_byte = 0;
        r = '{8'd0, 1'b0, 2'd0, 18'sd0, 32'd0};
        if (eor) begin
            r.is_final = 1'b1;
            r.result_code = (ph == PH_STATUS || ph == PH_HEADER) ? RC_NO_SEP : st_code;
            if (r.result_code == RC_OK)
                r.http_status = st_neg ? -$signed({1'b0, st_acc}) : $signed({1'b0, st_acc});
            if (ph == PH_CHUNK && sz_sub == SZ_DATA) r.discard_tail = emitted;
            body_expect.push_back(r);
            clear_parser();
            return;
        end
        last3 = {last3[15:0], c};
        case (ph)
            PH_STATUS: begin
                if (c == 8'd10 && prev == 8'd13) begin
                    if (st_spaces < 2) st_code = RC_BAD_LINE;
                    else if (!st_digit) st_code = RC_BAD_CODE;
                    else st_code = RC_OK;
                    ph = PH_HEADER;
                    new_line();
                end else if (st_spaces == 0) begin
                    if (c == 8'd32) st_spaces = 1;
                end else if (st_spaces == 1) begin
                    if (c == 8'd32) st_spaces = 2;
                    else status_char(c);
                end
            end
            PH_HEADER: begin
                if (c == 8'd10) begin
                    if (tail == 24'h0D0A0D) begin
                        last3 = 0; emitted = 0;
                        if (st_code != RC_OK) ph = PH_IGNORE;
                        else if (ck_mode) begin
                            ph = PH_CHUNK; sz_sub = SZ_WS; chunk_left = 0;
                        end else ph = PH_BODY;
                    end else begin
                        if (ln_mode == LN_CLEN && v_digit) begin
                            if (v_neg && v_acc != 0) len_ok = 0;
                            else begin
                                len_lim = v_acc; len_ok = 1;
                            end
                        end
                        new_line();
                    end
                end else field_char(c);
            end
            PH_BODY: begin
                if (!len_ok || emitted < len_lim) begin
                    out_byte = 1;
                    if (emitted != CNT_MAX) emitted++;
                end
            end
            PH_CHUNK: out_byte = chunk_byte(c, prev);
            default: ;
        endcase
        if (out_byte) begin
            r.body_byte = c;
            body_expect.push_back(r);
        end
    endtask

    // ---------------- stimulus builders ----------------
    task automatic push_beat(logic [7:0] b);
        pending_beats.push_back('{b, 1'b0, 1'b0});
    endtask
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_beat(s[i]);
    endtask
    task automatic push_end();
        pending_beats.push_back('{8'd0, 1'b1, 1'b0});
    endtask
    task automatic push_drain();
        pending_beats.push_back('{8'd0, 1'b0, 1'b1});
    endtask

    // random upper/lower case of a text
    function automatic string mixcase(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 2) == 0) t[i] = t[i] - 8'd32;
        return t;
    endfunction

    function automatic string status_token();
        case ($urandom_range(0, 9))
            0: return "-404";
            1: return "+  201";
            2: return "abc";
            3: return "123456789";
            4: return "";
            5: return "20x";
            default: return $sformatf("%0d", $urandom_range(100, 599));
        endcase
    endfunction

    task automatic random_header();
        case ($urandom_range(0, 7))
            0, 1: begin
                case ($urandom_range(0, 5))
                    0: push_text({mixcase("content-length"), ": abc"});
                    1: push_text({mixcase("content-length"), ": -5"});
                    2: push_text({mixcase("content-length"), ":-0"});
                    3: push_text({mixcase("content-length"), ": 99999999999"});
                    default: push_text({mixcase("content-length"), ": ",
                                        $sformatf("%0d", $urandom_range(0, 30))});
                endcase
            end
            2, 3: begin
                case ($urandom_range(0, 3))
                    0: push_text({mixcase("transfer-encoding"), ": gzip"});
                    1: push_text({mixcase("transfer-encoding"), ": cchunkeD"});
                    default: push_text({mixcase("transfer-encoding"), ": gzip, ",
                                        mixcase("chunked")});
                endcase
            end
            4: push_text({mixcase("content-lengthx"), ": 3"});
            5: push_text("Host: a.b");
            default: push_text({"X-", $sformatf("%0d", $urandom_range(0, 999)), ": v"});
        endcase
        if ($urandom_range(0, 7) == 0) push_beat(8'd10);
        else push_text("\r\n");
    endtask

    task automatic random_body_bytes(int n);
        for (int i = 0; i < n; i++) push_beat($urandom_range(0, 255));
    endtask

    task automatic random_chunks();
        int n, sz;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            sz = $urandom_range(1, 24);
            if ($urandom_range(0, 4) == 0) push_text(" ");
            if ($urandom_range(0, 4) == 0) push_text("0x");
            push_text(mixcase($sformatf("%0h", sz)));
            if ($urandom_range(0, 3) == 0) push_text(";ext=1");
            push_text("\r\n");
            if (k == n - 1 && $urandom_range(0, 4) == 0) begin
                random_body_bytes($urandom_range(0, sz - 1));
                return;
            end
            random_body_bytes(sz);
            random_body_bytes(2);
        end
        case ($urandom_range(0, 5))
            0: push_text("zz\r\n");
            1: push_text("100000000\r\n");
            2: ;
            default: push_text("0\r\n\r\n");
        endcase
        random_body_bytes($urandom_range(0, 4));
    endtask

    task automatic random_response();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            random_body_bytes($urandom_range(0, 30));
            push_end();
            return;
        end
        push_text("HTTP/1.1");
        if (kind == 1) push_text("_200");
        else push_text({" ", status_token(), " OK"});
        push_text("\r\n");
        for (int h = $urandom_range(0, 3); h > 0; h--) random_header();
        if (kind == 2) begin
            push_end();
            return;
        end
        push_text("\r\n");
        if ($urandom_range(0, 1) == 1) random_chunks();
        else random_body_bytes($urandom_range(0, 40));
        push_end();
    endtask

    // ---------------- driver ----------------
    int  gap_left = 0, burst_left = 1;
    bit  draining = 0;
    int  drain_hold = 0;
    always @(posedge aclk) begin
        beat_t b;
        bit    taken;
        bit    nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) begin
                deframe_beat(s_data_byte, s_end_of_response);
                idle_cycles = 0;
            end
            if (!s_valid || taken) begin
                nxt = 1'b0;
                if (draining) begin
                    if (body_expect.size() == 0) begin
                        if (drain_hold == 0) draining = 0;
                        else drain_hold--;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() > 0) begin
                    b = pending_beats.pop_front();
                    if (b.drain) begin
                        draining = 1; drain_hold = 4;
                    end else begin
                        s_data_byte <= b.data;
                        s_end_of_response <= b.eor;
                        nxt = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 40);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                        end
                    end
                end
                s_valid <= nxt;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    int stall_left = 0, run_left = 0, stall_mode = 0;
    always @(posedge aclk) begin
        if (run_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            run_left = $urandom_range(20, 200);
        end
        run_left--;
        if (stall_mode == 0) m_ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3 * stall_mode) == 0) stall_left = $urandom_range(1, 8);
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            idle_cycles = 0;
            if (body_expect.size() == 0) begin
                $display("%0t: unexpected beat body=%0h final=%0b", $time, m_body_byte,
                         m_is_final);
                err_cnt++;
            end else begin
                e = body_expect.pop_front();
                if (m_body_byte !== e.body_byte) begin
                    $display("%0t: body_byte exp %0h got %0h", $time, e.body_byte, m_body_byte);
                    err_cnt++;
                end
                if (m_is_final !== e.is_final) begin
                    $display("%0t: is_final exp %0b got %0b", $time, e.is_final, m_is_final);
                    err_cnt++;
                end
                if (m_result_code !== e.result_code) begin
                    $display("%0t: result_code exp %0d got %0d", $time, e.result_code,
                             m_result_code);
                    err_cnt++;
                end
                if (m_http_status !== e.http_status) begin
                    $display("%0t: http_status exp %0d got %0d", $time, e.http_status,
                             m_http_status);
                    err_cnt++;
                end
                if (m_discard_tail !== e.discard_tail) begin
                    $display("%0t: discard_tail exp %0d got %0d", $time, e.discard_tail,
                             m_discard_tail);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb_http_response_deframer_unit NOT OK");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        clear_parser();
        // end with nothing received
        push_end();
        // plain content-length body, cut to the length
        push_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
        push_beat(8'hFF); push_beat(8'h00); push_beat(8'hA5); push_beat(8'h5A);
        push_end();
        push_drain();
        // chunked with extension, then a chunk cut off by the end
        push_text("HTTP/1.1 -7 x\r\nTRANSFER-ENCODING: Chunked\r\n\r\n2;e\r\nab\r\n3\r\nq");
        push_end();
        // missing separator, status line without spaces, no digit, huge chunk size
        push_text("HTTP/1.1 200\r\nA: b\r\n");
        push_end();
        push_text("X\r\n\r\nz");
        push_end();
        push_text("H  \r\n\r\nz");
        push_end();
        push_text("H 9 \r\ntransfer-encoding:chunked\r\n\r\n100000000\r\n");
        push_end();
        push_drain();
        while (pending_beats.size() < 1350) begin
            random_response();
            if ($urandom_range(0, 30) == 0) push_drain();
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_beats.size() > 0 || s_valid || draining || body_expect.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) $display("tb_http_response_deframer_unit OK");
        else $display("tb_http_response_deframer_unit NOT OK");
        $finish;
    end

endmodule
